// ===== hdl/lom_pkg.sv =====
// Shared types and constants of the limit order matcher.
package lom_pkg;

  // Default configuration of the book.
  localparam int unsigned OrderSlotsDef = 64;
  localparam int unsigned PriceBitsDef  = 16;

  // Fixed field widths.
  localparam int unsigned IdW       = 32;
  localparam int unsigned QtyInW    = 32;
  localparam int unsigned InPriceW  = 16;
  localparam int unsigned QtyW      = 31;
  localparam int unsigned OutPriceW = 16;
  localparam int unsigned SpreadW   = 17;
  localparam int unsigned ArrW      = 32;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  // Phase of the work on one word.
  typedef enum logic {
    PH_INSERT,
    PH_MATCH
  } phase_e;

  // Update command for one slot cell.
  typedef struct packed {
    logic wr_new;
    logic take_fill;
  } cmd_t;

endpackage

// ===== hdl/lom_cell.sv =====
// One slot cell of the book: holds one order and passes the running best along the row.
module lom_cell #(
  parameter int unsigned PRICE_BITS = lom_pkg::PriceBitsDef,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lom_pkg::cmd_t            cmd_i,
  input  logic                     new_bid_i,
  input  logic [PRICE_BITS-1:0]    new_price_i,
  input  logic [lom_pkg::QtyW-1:0] new_rem_i,
  input  logic [lom_pkg::IdW-1:0]  new_ident_i,
  input  logic [lom_pkg::ArrW-1:0] arrival_now_i,
  input  logic [lom_pkg::QtyW-1:0] fill_i,
  input  logic                     free_f_i,
  input  logic [IDX_W-1:0]         free_idx_i,
  input  logic                     b_f_i,
  input  logic [PRICE_BITS-1:0]    b_price_i,
  input  logic [lom_pkg::ArrW-1:0] b_age_i,
  input  logic [IDX_W-1:0]         b_idx_i,
  input  logic [lom_pkg::QtyW-1:0] b_rem_i,
  input  logic                     a_f_i,
  input  logic [PRICE_BITS-1:0]    a_price_i,
  input  logic [lom_pkg::ArrW-1:0] a_age_i,
  input  logic [IDX_W-1:0]         a_idx_i,
  input  logic [lom_pkg::QtyW-1:0] a_rem_i,
  output logic                     free_f_o,
  output logic [IDX_W-1:0]         free_idx_o,
  output logic                     b_f_o,
  output logic [PRICE_BITS-1:0]    b_price_o,
  output logic [lom_pkg::ArrW-1:0] b_age_o,
  output logic [IDX_W-1:0]         b_idx_o,
  output logic [lom_pkg::QtyW-1:0] b_rem_o,
  output logic                     a_f_o,
  output logic [PRICE_BITS-1:0]    a_price_o,
  output logic [lom_pkg::ArrW-1:0] a_age_o,
  output logic [IDX_W-1:0]         a_idx_o,
  output logic [lom_pkg::QtyW-1:0] a_rem_o
);

  logic                     valid_q;
  logic                     is_bid_q;
  logic [PRICE_BITS-1:0]    price_q;
  logic [lom_pkg::QtyW-1:0] rem_q;
  logic [lom_pkg::IdW-1:0]  ident_q;
  logic [lom_pkg::ArrW-1:0] arr_q;

  logic [lom_pkg::ArrW-1:0] age;
  logic [lom_pkg::QtyW-1:0] rem_left;
  logic                     bid_take;
  logic                     ask_take;
  logic                     free_take;

  // Compare this slot against the best carried in from the left neighbor.
  always_comb begin
    age       = arrival_now_i - arr_q;
    rem_left  = rem_q - fill_i;
    bid_take  = valid_q && is_bid_q &&
                (!b_f_i || (price_q > b_price_i) ||
                 ((price_q == b_price_i) && (age > b_age_i)));
    ask_take  = valid_q && !is_bid_q &&
                (!a_f_i || (price_q < a_price_i) ||
                 ((price_q == a_price_i) && (age > a_age_i)));
    free_take = !valid_q && !free_f_i;
  end

  // Slot occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.wr_new) begin
      valid_q <= 1'b1;
    end else if (cmd_i.take_fill && (rem_left == '0)) begin
      valid_q <= 1'b0;
    end
  end

  // Slot contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new) begin
      is_bid_q <= new_bid_i;
      price_q  <= new_price_i;
      rem_q    <= new_rem_i;
      ident_q  <= new_ident_i;
      arr_q    <= arrival_now_i;
    end else if (cmd_i.take_fill) begin
      rem_q <= rem_left;
    end
  end

  // Hand the running best and first free slot to the right neighbor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_f_o <= 1'b0;
      b_f_o    <= 1'b0;
      a_f_o    <= 1'b0;
    end else begin
      free_f_o <= free_f_i || free_take;
      b_f_o    <= b_f_i || bid_take;
      a_f_o    <= a_f_i || ask_take;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_o <= free_take ? IDX_W'(CELL_IDX) : free_idx_i;
    b_price_o  <= bid_take ? price_q : b_price_i;
    b_age_o    <= bid_take ? age : b_age_i;
    b_idx_o    <= bid_take ? IDX_W'(CELL_IDX) : b_idx_i;
    b_rem_o    <= bid_take ? rem_q : b_rem_i;
    a_price_o  <= ask_take ? price_q : a_price_i;
    a_age_o    <= ask_take ? age : a_age_i;
    a_idx_o    <= ask_take ? IDX_W'(CELL_IDX) : a_idx_i;
    a_rem_o    <= ask_take ? rem_q : a_rem_i;
  end

endmodule

// ===== hdl/limit_order_matcher.sv =====
// Price-time priority limit order book with a row of slot cells.
//
// Input channel: in_valid_i / in_stall_o carry one order word (id, signed
// quantity, limit price). Output channel: out_valid_o / out_stall_i carry
// result words; an order gives one word per trade, or a single no-trade word,
// and its final word has last_o set and carries the spread.
// One order is worked on at a time; in_stall_o stays high until its final
// word has been loaded into the output register.
// Every look at the book is a scan through the row of ORDER_SLOTS cells, the
// running best moving one cell per cycle, followed by a decision. An order
// takes one scan to find a free slot and one more per trade plus one. A
// rejected order takes one scan. If the receiver stalls, the decision waits
// until the output register is free; nothing is lost. Reset empties the
// book, clears the arrival counter and the last trade price, and drops any
// pending word.
module limit_order_matcher #(
  parameter int unsigned ORDER_SLOTS = lom_pkg::OrderSlotsDef,
  parameter int unsigned PRICE_BITS  = lom_pkg::PriceBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lom_pkg::IdW-1:0]             ident_i,
  input  logic signed [lom_pkg::QtyInW-1:0]   quantity_i,
  input  logic [lom_pkg::InPriceW-1:0]        limit_px_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                trade_valid_o,
  output logic [lom_pkg::OutPriceW-1:0]       trade_price_o,
  output logic [lom_pkg::QtyW-1:0]            trade_quantity_o,
  output logic                                last_o,
  output logic                                rejected_o,
  output logic signed [lom_pkg::SpreadW-1:0]  spread_o,
  output logic [lom_pkg::OutPriceW-1:0]       last_trade_price_o
);

  localparam int unsigned IdxW = $clog2(ORDER_SLOTS);
  localparam int unsigned QtyW = lom_pkg::QtyW;
  localparam int unsigned ArrW = lom_pkg::ArrW;

  lom_pkg::state_e state_q, state_d;
  lom_pkg::phase_e phase_q, phase_d;

  logic [IdxW-1:0]               cnt_q;
  logic [lom_pkg::IdW-1:0]       ord_id_q;
  logic                          ord_bid_q;
  logic [PRICE_BITS-1:0]         ord_price_q;
  logic [QtyW-1:0]               ord_mag_q;
  logic [ArrW-1:0]               arrival_q;
  logic [lom_pkg::OutPriceW-1:0] recent_q;
  logic                          pend_q, pend_d;
  logic [lom_pkg::OutPriceW-1:0] pend_price_q, pend_price_d;
  logic [QtyW-1:0]               pend_qty_q, pend_qty_d;

  logic                          out_valid_q;
  logic                          out_trade_q, out_last_q, out_rej_q;
  logic [lom_pkg::OutPriceW-1:0] out_price_q, out_ltp_q;
  logic [QtyW-1:0]               out_qty_q;
  logic [lom_pkg::SpreadW-1:0]   out_spread_q;

  // Carry row between cells; entry 0 is the empty seed.
  logic                  c_free_f  [ORDER_SLOTS+1];
  logic [IdxW-1:0]       c_free_idx[ORDER_SLOTS+1];
  logic                  c_b_f     [ORDER_SLOTS+1];
  logic [PRICE_BITS-1:0] c_b_price [ORDER_SLOTS+1];
  logic [ArrW-1:0]       c_b_age   [ORDER_SLOTS+1];
  logic [IdxW-1:0]       c_b_idx   [ORDER_SLOTS+1];
  logic [QtyW-1:0]       c_b_rem   [ORDER_SLOTS+1];
  logic                  c_a_f     [ORDER_SLOTS+1];
  logic [PRICE_BITS-1:0] c_a_price [ORDER_SLOTS+1];
  logic [ArrW-1:0]       c_a_age   [ORDER_SLOTS+1];
  logic [IdxW-1:0]       c_a_idx   [ORDER_SLOTS+1];
  logic [QtyW-1:0]       c_a_rem   [ORDER_SLOTS+1];

  lom_pkg::cmd_t cmd[ORDER_SLOTS];

  logic                     in_accept;
  logic                     out_free;
  logic                     decide;
  logic                     crossed;
  logic                     do_insert;
  logic                     do_trade;
  logic                     do_emit;
  logic [PRICE_BITS-1:0]    tp;
  logic [QtyW-1:0]          fill;
  logic [33:0]              diff;
  logic [lom_pkg::SpreadW-1:0] spread_now;
  logic                     e_trade, e_last, e_rej;
  logic [lom_pkg::OutPriceW-1:0] e_price, e_ltp;
  logic [QtyW-1:0]          e_qty;
  logic [lom_pkg::SpreadW-1:0] e_spread;
  logic [lom_pkg::QtyInW-1:0]  q_abs;
  logic [QtyW-1:0]          q_mag;

  assign in_stall_o = (state_q != lom_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign decide     = (state_q == lom_pkg::S_DECIDE) && out_free;

  // Magnitude of the incoming quantity, saturated to 31 bits.
  always_comb begin
    q_abs = quantity_i[lom_pkg::QtyInW-1] ? (~quantity_i + 1'b1) : quantity_i;
    q_mag = q_abs[lom_pkg::QtyInW-1] ? '1 : q_abs[QtyW-1:0];
  end

  // Seed of the row.
  assign c_free_f[0]   = 1'b0;
  assign c_free_idx[0] = '0;
  assign c_b_f[0]      = 1'b0;
  assign c_b_price[0]  = '0;
  assign c_b_age[0]    = '0;
  assign c_b_idx[0]    = '0;
  assign c_b_rem[0]    = '0;
  assign c_a_f[0]      = 1'b0;
  assign c_a_price[0]  = '0;
  assign c_a_age[0]    = '0;
  assign c_a_idx[0]    = '0;
  assign c_a_rem[0]    = '0;

  // Row of slot cells.
  for (genvar gi = 0; gi < ORDER_SLOTS; gi++) begin : g_cell
    assign cmd[gi].wr_new    = do_insert && (c_free_idx[ORDER_SLOTS] == IdxW'(gi));
    assign cmd[gi].take_fill = do_trade &&
                               ((c_b_idx[ORDER_SLOTS] == IdxW'(gi)) ||
                                (c_a_idx[ORDER_SLOTS] == IdxW'(gi)));
    lom_cell #(
      .PRICE_BITS(PRICE_BITS),
      .IDX_W     (IdxW),
      .CELL_IDX  (gi)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd[gi]),
      .new_bid_i    (ord_bid_q),
      .new_price_i  (ord_price_q),
      .new_rem_i    (ord_mag_q),
      .new_ident_i  (ord_id_q),
      .arrival_now_i(arrival_q),
      .fill_i       (fill),
      .free_f_i     (c_free_f[gi]),
      .free_idx_i   (c_free_idx[gi]),
      .b_f_i        (c_b_f[gi]),
      .b_price_i    (c_b_price[gi]),
      .b_age_i      (c_b_age[gi]),
      .b_idx_i      (c_b_idx[gi]),
      .b_rem_i      (c_b_rem[gi]),
      .a_f_i        (c_a_f[gi]),
      .a_price_i    (c_a_price[gi]),
      .a_age_i      (c_a_age[gi]),
      .a_idx_i      (c_a_idx[gi]),
      .a_rem_i      (c_a_rem[gi]),
      .free_f_o     (c_free_f[gi+1]),
      .free_idx_o   (c_free_idx[gi+1]),
      .b_f_o        (c_b_f[gi+1]),
      .b_price_o    (c_b_price[gi+1]),
      .b_age_o      (c_b_age[gi+1]),
      .b_idx_o      (c_b_idx[gi+1]),
      .b_rem_o      (c_b_rem[gi+1]),
      .a_f_o        (c_a_f[gi+1]),
      .a_price_o    (c_a_price[gi+1]),
      .a_age_o      (c_a_age[gi+1]),
      .a_idx_o      (c_a_idx[gi+1]),
      .a_rem_o      (c_a_rem[gi+1])
    );
  end

  // Scan results at the end of the row.
  always_comb begin
    crossed    = c_b_f[ORDER_SLOTS] && c_a_f[ORDER_SLOTS] &&
                 (c_b_price[ORDER_SLOTS] >= c_a_price[ORDER_SLOTS]);
    tp         = ord_bid_q ? c_a_price[ORDER_SLOTS] : c_b_price[ORDER_SLOTS];
    diff       = 34'(c_a_price[ORDER_SLOTS]) - 34'(c_b_price[ORDER_SLOTS]);
    spread_now = (c_b_f[ORDER_SLOTS] && c_a_f[ORDER_SLOTS]) ?
                 diff[lom_pkg::SpreadW-1:0] : '1;
    // Fill is the smaller remaining quantity of the two best slots.
    fill       = (c_b_rem[ORDER_SLOTS] < c_a_rem[ORDER_SLOTS]) ?
                 c_b_rem[ORDER_SLOTS] : c_a_rem[ORDER_SLOTS];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lom_pkg::S_IDLE: begin
        if (in_accept) state_d = lom_pkg::S_SCAN;
      end
      lom_pkg::S_SCAN: begin
        if (cnt_q == IdxW'(ORDER_SLOTS - 1)) state_d = lom_pkg::S_DECIDE;
      end
      lom_pkg::S_DECIDE: begin
        if (decide) begin
          if (do_insert || do_trade) state_d = lom_pkg::S_SCAN;
          else                       state_d = lom_pkg::S_IDLE;
        end
      end
      default: state_d = lom_pkg::S_IDLE;
    endcase
  end

  // Decision outputs: slot writes, trades and result words.
  always_comb begin
    do_insert    = 1'b0;
    do_trade     = 1'b0;
    do_emit      = 1'b0;
    phase_d      = phase_q;
    pend_d       = pend_q;
    pend_price_d = pend_price_q;
    pend_qty_d   = pend_qty_q;
    e_trade      = 1'b0;
    e_last       = 1'b1;
    e_rej        = 1'b0;
    e_price      = '0;
    e_qty        = '0;
    e_spread     = spread_now;
    e_ltp        = recent_q;
    if (in_accept) begin
      phase_d = lom_pkg::PH_INSERT;
      pend_d  = 1'b0;
    end else if (decide) begin
      unique case (phase_q)
        lom_pkg::PH_INSERT: begin
          if ((ord_mag_q == '0) || !c_free_f[ORDER_SLOTS]) begin
            do_emit = 1'b1;
            e_rej   = 1'b1;
          end else begin
            do_insert = 1'b1;
            phase_d   = lom_pkg::PH_MATCH;
          end
        end
        lom_pkg::PH_MATCH: begin
          if (crossed) begin
            do_trade     = 1'b1;
            pend_d       = 1'b1;
            pend_price_d = lom_pkg::OutPriceW'(tp);
            pend_qty_d   = fill;
            if (pend_q) begin
              do_emit  = 1'b1;
              e_last   = 1'b0;
              e_spread = '0;
            end
          end else begin
            do_emit = 1'b1;
            pend_d  = 1'b0;
          end
          if (pend_q) begin
            e_trade = 1'b1;
            e_price = pend_price_q;
            e_qty   = pend_qty_q;
            e_ltp   = pend_price_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lom_pkg::S_IDLE;
      phase_q   <= lom_pkg::PH_INSERT;
      cnt_q     <= '0;
      arrival_q <= '0;
      recent_q  <= '0;
      pend_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      cnt_q   <= (state_q == lom_pkg::S_SCAN) ? cnt_q + 1'b1 : '0;
      if (do_insert) arrival_q <= arrival_q + 1'b1;
      if (do_trade)  recent_q  <= lom_pkg::OutPriceW'(tp);
      if (do_emit)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Order and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ord_id_q    <= ident_i;
      ord_bid_q   <= !quantity_i[lom_pkg::QtyInW-1];
      ord_price_q <= PRICE_BITS'(limit_px_i);
      ord_mag_q   <= q_mag;
    end
    pend_price_q <= pend_price_d;
    pend_qty_q   <= pend_qty_d;
    if (do_emit) begin
      out_trade_q  <= e_trade;
      out_last_q   <= e_last;
      out_rej_q    <= e_rej;
      out_price_q  <= e_price;
      out_qty_q    <= e_qty;
      out_spread_q <= e_spread;
      out_ltp_q    <= e_ltp;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign trade_valid_o      = out_trade_q;
  assign trade_price_o      = out_price_q;
  assign trade_quantity_o   = out_qty_q;
  assign last_o             = out_last_q;
  assign rejected_o         = out_rej_q;
  assign spread_o           = out_spread_q;
  assign last_trade_price_o = out_ltp_q;

endmodule

// ===== hdl/lom_checker.sv =====
// Port-level checks of the limit order matcher and their binding.
module lom_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               trade_valid_o,
  input logic [lom_pkg::OutPriceW-1:0]      trade_price_o,
  input logic [lom_pkg::QtyW-1:0]           trade_quantity_o,
  input logic                               last_o,
  input logic                               rejected_o,
  input logic signed [lom_pkg::SpreadW-1:0] spread_o
);

  // A stalled word stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A rejected order gives only a final no-trade word.
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> last_o && !trade_valid_o)
    else $error("rejected word is not a final no-trade word");

  // A no-trade word carries no price and no quantity.
  a_notrade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !trade_valid_o |-> trade_price_o == '0 && trade_quantity_o == '0)
    else $error("no-trade word carries trade data");

  // Words before the final one are trades without a spread.
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> trade_valid_o && spread_o == '0)
    else $error("non-final word is malformed");

  // A trade always fills something.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trade_valid_o |-> trade_quantity_o != '0)
    else $error("trade of zero quantity");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .trade_valid_o   (trade_valid_o),
  .trade_price_o   (trade_price_o),
  .trade_quantity_o(trade_quantity_o),
  .last_o          (last_o),
  .rejected_o      (rejected_o),
  .spread_o        (spread_o)
);
